// ===== rtl/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, register map, codes and encoding helpers for the CMOS clock
// register file.
// ----------------------------------------------------------------------------
package crf_pkg;

    localparam int REG_COUNT_DEF = 64;

    // Request opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // Register map
    localparam logic [5:0] REG_SEC       = 6'h00;
    localparam logic [5:0] REG_ALARM_SEC = 6'h01;
    localparam logic [5:0] REG_MIN       = 6'h02;
    localparam logic [5:0] REG_ALARM_MIN = 6'h03;
    localparam logic [5:0] REG_HOUR      = 6'h04;
    localparam logic [5:0] REG_ALARM_HR  = 6'h05;
    localparam logic [5:0] REG_WEEKDAY   = 6'h06;
    localparam logic [5:0] REG_DAY       = 6'h07;
    localparam logic [5:0] REG_MONTH     = 6'h08;
    localparam logic [5:0] REG_YEAR      = 6'h09;
    localparam logic [5:0] REG_A         = 6'h0A;
    localparam logic [5:0] REG_B         = 6'h0B;
    localparam logic [5:0] REG_C         = 6'h0C;
    localparam logic [5:0] REG_D         = 6'h0D;

    // Clock field codes
    localparam logic [2:0] FLD_SEC     = 3'd0;
    localparam logic [2:0] FLD_MIN     = 3'd1;
    localparam logic [2:0] FLD_HOUR    = 3'd2;
    localparam logic [2:0] FLD_WEEKDAY = 3'd3;
    localparam logic [2:0] FLD_DAY     = 3'd4;
    localparam logic [2:0] FLD_MONTH   = 3'd5;
    localparam logic [2:0] FLD_YEAR    = 3'd6;

    localparam logic [7:0] REG_D_VALUE = 8'h80;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] reg_index;
        logic [7:0] write_data;
        logic [5:0] clock_seconds;
        logic [5:0] clock_minutes;
        logic [4:0] clock_hours;
        logic [2:0] clock_weekday;
        logic [4:0] clock_day;
        logic [3:0] clock_month;
        logic [7:0] clock_year_offset;
    } crf_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clock_write_valid;
        logic [2:0] clock_field;
        logic [7:0] clock_value;
    } crf_rsp_t;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'({4'b0000, b[7:4]} * 8'd10) + {4'b0000, b[3:0]};
    endfunction

    // Divide by ten through a reciprocal multiply; exact for all 8-bit values
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [18:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 19'(v) * 19'd205;
        q = 8'(p >> 11);
        r = v - 8'(q * 8'd10);
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [7:0] enc(input logic [7:0] v, input logic bcd);
        return bcd ? to_bcd(v) : v;
    endfunction

    function automatic logic [7:0] to12(input logic [7:0] h);
        logic [7:0] res;
        res = h;
        if (h == 8'd0)
            res = 8'd12;
        else if (h >= 8'd13 && h <= 8'd23)
            res = h - 8'd12;
        return res;
    endfunction

    function automatic logic [7:0] enc_hour(input logic [7:0] h, input logic bcd,
                                            input logic h24);
        return enc(h24 ? h : to12(h), bcd);
    endfunction

    function automatic logic [7:0] mod100(input logic [7:0] y);
        logic [7:0] res;
        res = y;
        if (y >= 8'd200)
            res = y - 8'd200;
        else if (y >= 8'd100)
            res = y - 8'd100;
        return res;
    endfunction

endpackage

// ===== rtl/crf_ram.sv =====
// ----------------------------------------------------------------------------
// crf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cmos_rtc_register_file.sv =====
// ----------------------------------------------------------------------------
// cmos_rtc_register_file
// MC146818-style register file: 64 host registers backed by clock, alarm and
// mode registers and a CMOS byte store held in a synchronous RAM.
//
// One request is taken per clock cycle while the response side is not stalled,
// and each gives exactly one response: the decode stage decodes the request
// and issues the CMOS store access, and the output register, once free, picks
// up the registered RAM read data. The store comes out of reset all zero via a
// per-entry valid bit, so no clearing pass is needed and requests are taken
// right after reset. Writes that repeat the previous write exactly are
// dropped and answered with an all-zero response.
// ----------------------------------------------------------------------------
module cmos_rtc_register_file #(
    parameter int REG_COUNT = crf_pkg::REG_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  crf_pkg::crf_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output crf_pkg::crf_rsp_t rsp
);
    import crf_pkg::*;

    localparam int ADDR_W = $clog2(REG_COUNT);

    // Clock, alarm and mode state
    logic [7:0] sec_reg, min_reg, hour_reg, wday_reg, day_reg, month_reg, year_reg;
    logic [7:0] sec_next, min_next, hour_next, wday_next, day_next, month_next,
                year_next;
    logic [7:0] asec_reg, amin_reg, ahour_reg;
    logic [7:0] asec_next, amin_next, ahour_next;
    logic       bcd_reg, h24_reg, bcd_next, h24_next;
    logic       last_valid_reg, last_valid_next;
    logic [5:0] last_idx_reg, last_idx_next;
    logic [7:0] last_byte_reg, last_byte_next;
    logic [REG_COUNT-1:0] store_valid_reg, store_valid_next;

    // Decode stage and output register
    logic     s1_valid_reg, s1_valid_next;
    crf_rsp_t s1_rsp_reg, s1_rsp_next;
    logic     s1_use_ram_reg, s1_use_ram_next;
    logic     rsp_valid_reg, rsp_valid_next;
    crf_rsp_t rsp_reg, rsp_next;

    logic              accept, s1_advance, is_dup, in_range, is_store_reg;
    logic [7:0]        dec;
    logic [ADDR_W-1:0] addr;
    logic              ram_we, ram_re;
    logic [7:0]        ram_wdata, ram_rdata;

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready  = !s1_valid_reg || s1_advance;
    assign accept     = cmd_valid && cmd_ready;

    assign addr     = ADDR_W'(cmd.reg_index);
    assign in_range = 32'(cmd.reg_index) < REG_COUNT;
    assign is_dup   = last_valid_reg && (last_idx_reg == cmd.reg_index)
                      && (last_byte_reg == cmd.write_data);
    assign dec      = bcd_reg ? from_bcd(cmd.write_data) : cmd.write_data;
    assign is_store_reg = !(cmd.reg_index inside {[REG_SEC:REG_YEAR], REG_C, REG_D});

    crf_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        wday_next  = wday_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        asec_next  = asec_reg;
        amin_next  = amin_reg;
        ahour_next = ahour_reg;
        bcd_next   = bcd_reg;
        h24_next   = h24_reg;
        last_valid_next  = last_valid_reg;
        last_idx_next    = last_idx_reg;
        last_byte_next   = last_byte_reg;
        store_valid_next = store_valid_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = cmd.write_data;
        s1_rsp_next     = '0;
        s1_use_ram_next = 1'b0;

        if (accept)
        begin
            case (cmd.opcode)
                OP_WRITE:
                begin
                    if (!is_dup)
                    begin
                        last_valid_next = 1'b1;
                        last_idx_next   = cmd.reg_index;
                        last_byte_next  = cmd.write_data;
                        s1_rsp_next.clock_value = dec;
                        case (cmd.reg_index)
                            REG_SEC:
                            begin
                                sec_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_SEC;
                            end
                            REG_ALARM_SEC: asec_next = dec;
                            REG_MIN:
                            begin
                                min_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_MIN;
                            end
                            REG_ALARM_MIN: amin_next = dec;
                            REG_HOUR:
                            begin
                                hour_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_HOUR;
                            end
                            REG_ALARM_HR: ahour_next = dec;
                            REG_WEEKDAY:
                            begin
                                wday_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_WEEKDAY;
                            end
                            REG_DAY:
                            begin
                                day_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_DAY;
                            end
                            REG_MONTH:
                            begin
                                month_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_MONTH;
                            end
                            REG_YEAR:
                            begin
                                year_next = dec;
                                s1_rsp_next.clock_write_valid = 1'b1;
                                s1_rsp_next.clock_field = FLD_YEAR;
                            end
                            REG_B:
                            begin
                                bcd_next = !cmd.write_data[2];
                                h24_next = cmd.write_data[1];
                            end
                            default: ;
                        endcase
                        if (!s1_rsp_next.clock_write_valid)
                            s1_rsp_next.clock_value = '0;
                        if (is_store_reg && in_range)
                        begin
                            ram_we = 1'b1;
                            if (cmd.reg_index == REG_A)
                                ram_wdata = {1'b0, cmd.write_data[6:0]};
                            store_valid_next[addr] = 1'b1;
                        end
                    end
                end
                OP_READ:
                begin
                    case (cmd.reg_index)
                        REG_SEC:       s1_rsp_next.read_data = enc(sec_reg, bcd_reg);
                        REG_ALARM_SEC: s1_rsp_next.read_data = enc(asec_reg, bcd_reg);
                        REG_MIN:       s1_rsp_next.read_data = enc(min_reg, bcd_reg);
                        REG_ALARM_MIN: s1_rsp_next.read_data = enc(amin_reg, bcd_reg);
                        REG_HOUR:
                            s1_rsp_next.read_data = enc_hour(hour_reg, bcd_reg, h24_reg);
                        REG_ALARM_HR:
                            s1_rsp_next.read_data = enc_hour(ahour_reg, bcd_reg, h24_reg);
                        REG_WEEKDAY:   s1_rsp_next.read_data = enc(wday_reg, bcd_reg);
                        REG_DAY:       s1_rsp_next.read_data = enc(day_reg, bcd_reg);
                        REG_MONTH:     s1_rsp_next.read_data = enc(month_reg, bcd_reg);
                        REG_YEAR:
                            s1_rsp_next.read_data = enc(mod100(year_reg), bcd_reg);
                        REG_C:         s1_rsp_next.read_data = '0;
                        REG_D:         s1_rsp_next.read_data = REG_D_VALUE;
                        default:
                        begin
                            // never-written entries read as zero
                            if (in_range && store_valid_reg[addr])
                            begin
                                ram_re = 1'b1;
                                s1_use_ram_next = 1'b1;
                            end
                        end
                    endcase
                end
                OP_UPDATE:
                begin
                    sec_next   = 8'(cmd.clock_seconds);
                    min_next   = 8'(cmd.clock_minutes);
                    hour_next  = 8'(cmd.clock_hours);
                    wday_next  = 8'(cmd.clock_weekday);
                    day_next   = 8'(cmd.clock_day);
                    month_next = 8'(cmd.clock_month);
                    year_next  = cmd.clock_year_offset;
                end
                default: ;
            endcase
        end

        // Hold the decoded request until the output register frees up
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        rsp_next = rsp_reg;
        if (s1_advance)
        begin
            rsp_next = s1_rsp_reg;
            if (s1_use_ram_reg)
                rsp_next.read_data = ram_rdata;
        end

        if (s1_advance)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= 8'd0;
            min_reg   <= 8'd0;
            hour_reg  <= 8'd0;
            wday_reg  <= 8'd1;
            day_reg   <= 8'd1;
            month_reg <= 8'd1;
            year_reg  <= 8'd0;
            asec_reg  <= 8'd0;
            amin_reg  <= 8'd0;
            ahour_reg <= 8'd0;
            bcd_reg   <= 1'b1;
            h24_reg   <= 1'b0;
            last_valid_reg  <= 1'b0;
            last_idx_reg    <= '0;
            last_byte_reg   <= '0;
            store_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            wday_reg  <= wday_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            asec_reg  <= asec_next;
            amin_reg  <= amin_next;
            ahour_reg <= ahour_next;
            bcd_reg   <= bcd_next;
            h24_reg   <= h24_next;
            last_valid_reg  <= last_valid_next;
            last_idx_reg    <= last_idx_next;
            last_byte_reg   <= last_byte_next;
            store_valid_reg <= store_valid_next;
            s1_valid_reg    <= s1_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg     <= s1_rsp_next;
            s1_use_ram_reg <= s1_use_ram_next;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
